[rtl/core/dbfs_pkg.sv]
package dbfs_pkg;

   // Frame geometry
   localparam int ROWS   = 16;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ADDR_W = ROW_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int PIX_W  = 8;

   // Row arithmetic: row_base (4 bits) plus run offset (5 bits), compared to ROWS
   localparam int SUM_W  = 7;
   localparam int RUN_W  = 5;

   // Request opcodes
   typedef enum logic [2:0] {
      OP_OR     = 3'd0,
      OP_ANDNOT = 3'd1,
      OP_ZERO   = 3'd2,
      OP_SET    = 3'd3,
      OP_CLEAR  = 3'd4,
      OP_FLUSH  = 3'd5,
      OP_FRAME  = 3'd6,
      OP_READ   = 3'd7
   } op_type;

   // Color plane codes
   localparam logic COLOR_RED   = 1'b0;
   localparam logic COLOR_GREEN = 1'b1;

endpackage

[rtl/core/dbfs_ram.sv]
module dbfs_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [dbfs_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [dbfs_pkg::PIX_W-1:0]   wr_data,
   input  logic [dbfs_pkg::ADDR_W-1:0]  rd_addr,
   output logic [dbfs_pkg::PIX_W-1:0]   rd_data
);
   import dbfs_pkg::*;

   // One plane: address is {bank, row}
   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/double_buffered_led_frame_store.sv]
// Two-color 16x8 LED frame store with front and back banks per plane. A
// request is taken when start is high and busy is low. Draw requests (OR,
// AND-NOT, zero row, set pixel, clear pixel) make one read of the plane
// memory, then the modify and write-back; reads and a frame-done with
// nothing pending make only the read. Flush and a frame-done that swaps the
// banks walk the bank one row per cycle. After reset the block holds busy
// high while it clears both banks of both planes, one memory address at a
// time; requests are taken after that.
// The response appears on the rsp_ ports for exactly one cycle with
// rsp_valid high, in the cycle after the last memory access of the request;
// there is no way to hold it off, so the receiver must take it in that cycle.
module double_buffered_led_frame_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_op,
   input  logic                       req_color,
   input  logic [3:0]                 req_row_base,
   input  logic [dbfs_pkg::PIX_W-1:0] req_sprite_byte,
   input  logic                       req_wrap_enable,
   input  logic                       req_run_last,
   input  logic [2:0]                 req_pixel_x,
   output logic                       rsp_valid,
   output logic [dbfs_pkg::PIX_W-1:0] rsp_front_red_row,
   output logic [dbfs_pkg::PIX_W-1:0] rsp_front_green_row,
   output logic                       rsp_front_bank,
   output logic                       rsp_swapped
);
   import dbfs_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_FLUSH,
      ST_COPY
   } state_type;

   localparam logic [SUM_W-1:0]  ROWS_S    = SUM_W'(ROWS);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   state_type         state_ff;
   logic              front_ff;
   logic              pending_ff;
   logic [RUN_W-1:0]  run_offset_ff;
   logic [ROW_W-1:0]  cnt_ff;
   logic [ADDR_W-1:0] clr_ff;

   // Request held for the write-back cycle
   op_type           op_ff;
   logic             color_ff;
   logic [PIX_W-1:0] byte_ff;
   logic [PIX_W-1:0] mask_ff;
   logic [ROW_W-1:0] row_ff;
   logic             ok_ff;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_red_ff;
   logic [PIX_W-1:0] rsp_green_ff;
   logic             rsp_bank_ff;
   logic             rsp_swapped_ff;

   logic             accept;
   op_type           req_op_t;
   logic [SUM_W-1:0] run_sum;
   logic [SUM_W-1:0] run_wrap;
   logic [SUM_W-1:0] tgt_row;
   logic             tgt_ok;
   logic [PIX_W-1:0] px_mask;
   logic             swap_req;

   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [PIX_W-1:0]  rd_red;
   logic [PIX_W-1:0]  rd_green;
   logic [PIX_W-1:0]  wr_red;
   logic [PIX_W-1:0]  wr_green;
   logic              we_red;
   logic              we_green;
   logic [PIX_W-1:0]  cur_row;
   logic [PIX_W-1:0]  new_row;
   logic              is_draw;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign req_op_t = op_type'(req_op);
   assign swap_req = (req_op_t == OP_FRAME) && pending_ff;
   assign px_mask  = PIX_W'(8'h80 >> req_pixel_x);

   // Target row: run rows add the kept offset and may wrap once
   assign run_sum  = SUM_W'(req_row_base) + SUM_W'(run_offset_ff);
   assign run_wrap = run_sum - ROWS_S;

   always_comb begin
      tgt_row = SUM_W'(req_row_base);
      tgt_ok  = (SUM_W'(req_row_base) < ROWS_S);
      if (req_op_t == OP_OR || req_op_t == OP_ANDNOT || req_op_t == OP_ZERO) begin
         if (run_sum < ROWS_S) begin
            tgt_row = run_sum;
            tgt_ok  = 1'b1;
         end else if (req_wrap_enable && (run_wrap < ROWS_S)) begin
            tgt_row = run_wrap;
            tgt_ok  = 1'b1;
         end else begin
            tgt_row = run_sum;
            tgt_ok  = 1'b0;
         end
      end
   end

   // Read address: request row on accept (row 0 of the new front bank for a swap), next front row while copying
   always_comb begin
      rd_addr = {front_ff, cnt_ff + ROW_W'(1)};
      if (accept) begin
         priority if (req_op_t == OP_READ) begin
            rd_addr = {front_ff, tgt_row[ROW_W-1:0]};
         end else if (swap_req) begin
            rd_addr = {~front_ff, {ROW_W{1'b0}}};
         end else begin
            rd_addr = {~front_ff, tgt_row[ROW_W-1:0]};
         end
      end
   end

   // Modify step for draw requests
   assign is_draw = (op_ff == OP_OR) || (op_ff == OP_ANDNOT) || (op_ff == OP_ZERO)
                 || (op_ff == OP_SET) || (op_ff == OP_CLEAR);
   assign cur_row = (color_ff == COLOR_GREEN) ? rd_green : rd_red;

   always_comb begin
      unique case (op_ff)
         OP_OR:     new_row = cur_row | byte_ff;
         OP_ANDNOT: new_row = cur_row & ~byte_ff;
         OP_SET:    new_row = cur_row | mask_ff;
         OP_CLEAR:  new_row = cur_row & ~mask_ff;
         default:   new_row = '0;
      endcase
   end

   // Write port: clearing pass, draw write-back, flush sweep, or bank copy
   always_comb begin
      wr_addr  = {~front_ff, row_ff};
      wr_red   = new_row;
      wr_green = new_row;
      we_red   = 1'b0;
      we_green = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_addr  = clr_ff;
            wr_red   = '0;
            wr_green = '0;
            we_red   = 1'b1;
            we_green = 1'b1;
         end
         ST_ACCESS: begin
            we_red   = is_draw && ok_ff && (color_ff == COLOR_RED);
            we_green = is_draw && ok_ff && (color_ff == COLOR_GREEN);
         end
         ST_FLUSH: begin
            wr_addr  = {~front_ff, cnt_ff};
            wr_red   = '0;
            wr_green = '0;
            we_red   = (color_ff == COLOR_RED);
            we_green = (color_ff == COLOR_GREEN);
         end
         ST_COPY: begin
            wr_addr  = {~front_ff, cnt_ff};
            wr_red   = rd_red;
            wr_green = rd_green;
            we_red   = 1'b1;
            we_green = 1'b1;
         end
         default: begin
            we_red   = 1'b0;
            we_green = 1'b0;
         end
      endcase
   end

   dbfs_ram u_red_ram (
      .clock   (clock),
      .wr_en   (we_red),
      .wr_addr (wr_addr),
      .wr_data (wr_red),
      .rd_addr (rd_addr),
      .rd_data (rd_red)
   );

   dbfs_ram u_green_ram (
      .clock   (clock),
      .wr_en   (we_green),
      .wr_addr (wr_addr),
      .wr_data (wr_green),
      .rd_addr (rd_addr),
      .rd_data (rd_green)
   );

   // Sequencer, bank pointers and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         front_ff      <= 1'b0;
         pending_ff    <= 1'b0;
         run_offset_ff <= '0;
         cnt_ff        <= '0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               rsp_valid_ff <= 1'b0;
               clr_ff       <= clr_ff + ADDR_W'(1);
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  op_ff    <= req_op_t;
                  color_ff <= req_color;
                  byte_ff  <= req_sprite_byte;
                  mask_ff  <= px_mask;
                  row_ff   <= tgt_row[ROW_W-1:0];
                  ok_ff    <= tgt_ok;
                  cnt_ff   <= '0;
                  if (req_op_t == OP_OR || req_op_t == OP_ANDNOT || req_op_t == OP_ZERO)
                  begin
                     run_offset_ff <= req_run_last ? '0 : run_offset_ff + RUN_W'(1);
                  end
                  if (req_op_t == OP_OR || req_op_t == OP_ANDNOT || req_op_t == OP_ZERO
                      || req_op_t == OP_SET || req_op_t == OP_CLEAR) begin
                     pending_ff <= 1'b1;
                  end
                  priority if (req_op_t == OP_FLUSH) begin
                     state_ff <= ST_FLUSH;
                  end else if (swap_req) begin
                     pending_ff <= 1'b0;
                     front_ff   <= ~front_ff;
                     state_ff   <= ST_COPY;
                  end else begin
                     state_ff <= ST_ACCESS;
                  end
               end
            end
            ST_ACCESS: begin
               rsp_valid_ff   <= 1'b1;
               rsp_red_ff     <= (op_ff == OP_READ && ok_ff) ? rd_red : '0;
               rsp_green_ff   <= (op_ff == OP_READ && ok_ff) ? rd_green : '0;
               rsp_bank_ff    <= front_ff;
               rsp_swapped_ff <= 1'b0;
               state_ff       <= ST_IDLE;
            end
            ST_FLUSH, ST_COPY: begin
               if (cnt_ff == LAST_ROW) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_red_ff     <= '0;
                  rsp_green_ff   <= '0;
                  rsp_bank_ff    <= front_ff;
                  rsp_swapped_ff <= (state_ff == ST_COPY);
                  cnt_ff         <= '0;
                  state_ff       <= ST_IDLE;
               end else begin
                  rsp_valid_ff <= 1'b0;
                  cnt_ff       <= cnt_ff + ROW_W'(1);
               end
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_front_red_row   = rsp_red_ff;
   assign rsp_front_green_row = rsp_green_ff;
   assign rsp_front_bank      = rsp_bank_ff;
   assign rsp_swapped         = rsp_swapped_ff;

   // A response is only shown once the sequencer is back in idle
   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe outside idle");

   // A plain request, once taken, enters the access state
   a_single_access: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op_t != OP_FLUSH && !swap_req) |=> (state_ff == ST_ACCESS))
      else $error("plain request did not enter access cycle");

   // No memory write while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (we_red || we_green) |-> (state_ff != ST_IDLE))
      else $error("plane write while idle");

   // A bank copy writes both planes every cycle
   a_copy_both: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (we_red && we_green))
      else $error("copy skipped a plane");

   // After a swap nothing is left pending
   a_swap_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_swapped_ff) |-> !pending_ff)
      else $error("update still pending after swap");

endmodule
